/* sv/assert_macros.svh */
// Assertion macros shared by the RTL of the quadrature position sampler.
// Simulation gets concurrent assertions; synthesis sees empty bodies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Assert that prop holds at every clock edge outside reset.
`define QPS_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Assert that cons holds in the cycle after ante.
`define QPS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`else

`define QPS_ASSERT(lbl, clk, rst_n, prop, msg)
`define QPS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg)

`endif

`endif

/* sv/qps_pkg.sv */
// Shared types and constants of the quadrature position sampler.
// No dependencies; used by qps_core, qps_out_queue and the top level.
`timescale 1ns / 1ps

package qps_pkg;

    localparam int CPT_W = 15;
    localparam int POS_W = 16;
    localparam int BYTE_W = 8;
    localparam int FUNC_W = 3;

    localparam logic [CPT_W-1:0] CPT_RESET = 15'd910;
    localparam logic [BYTE_W-1:0] CONNECT_BYTE = 8'd98;
    localparam logic [BYTE_W-1:0] BEACON_BYTE = 8'h61;

    localparam logic [FUNC_W-1:0] FUNC_EDGE_A = 3'd0;
    localparam logic [FUNC_W-1:0] FUNC_EDGE_B = 3'd1;
    localparam logic [FUNC_W-1:0] FUNC_SAMPLE = 3'd2;
    localparam logic [FUNC_W-1:0] FUNC_RX = 3'd3;
    localparam logic [FUNC_W-1:0] FUNC_BEACON = 3'd4;

    // One outgoing serial word.
    typedef struct packed {
        logic [BYTE_W-1:0] data;
        logic              last;
    } t_word;

    // Words produced by one accepted item, in order.
    typedef struct packed {
        logic [1:0] count;
        t_word      w0;
        t_word      w1;
    } t_push;

endpackage

/* sv/qps_core.sv */
// Encoder state, link state and word generation for each accepted item.
// Depends on qps_pkg.
`timescale 1ns / 1ps

module qps_core (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_accept,
    input  logic [qps_pkg::FUNC_W-1:0]  i_func,
    input  logic                        i_other_level,
    input  logic [qps_pkg::BYTE_W-1:0]  i_rx_byte,
    input  logic                        i_cfg_we,
    input  logic [qps_pkg::CPT_W-1:0]   i_cfg_data,
    output qps_pkg::t_push              o_push,
    output logic                        o_connected
);
    import qps_pkg::*;

    logic [CPT_W-1:0] r_cpt;
    logic [POS_W-1:0] r_position, n_position;
    logic             r_a_rising, n_a_rising;
    logic             r_b_rising, n_b_rising;
    logic             r_connected, n_connected;

    logic [POS_W-1:0] pos_up, pos_down;
    logic             match_a, match_b;

    always_comb begin
        pos_up   = (r_position == {1'b0, r_cpt}) ? POS_W'(1) : r_position + POS_W'(1);
        pos_down = (r_position == '0) ? {1'b0, r_cpt} : r_position - POS_W'(1);
        // Match means falling with the other channel high, or rising with it low.
        match_a  = r_a_rising ^ i_other_level;
        match_b  = r_b_rising ^ i_other_level;
    end

    always_comb begin
        n_position  = r_position;
        n_a_rising  = r_a_rising;
        n_b_rising  = r_b_rising;
        n_connected = r_connected;
        o_push      = '0;
        unique case (i_func)
            FUNC_EDGE_A: begin
                n_position = match_a ? pos_up : pos_down;
                n_a_rising = ~r_a_rising;
            end
            FUNC_EDGE_B: begin
                n_position = match_b ? pos_down : pos_up;
                n_b_rising = ~r_b_rising;
            end
            FUNC_SAMPLE: begin
                if (r_connected) begin
                    o_push.count = 2'd2;
                    o_push.w0    = '{data: r_position[BYTE_W-1:0], last: 1'b0};
                    o_push.w1    = '{data: r_position[POS_W-1:BYTE_W], last: 1'b1};
                end
            end
            FUNC_RX: begin
                if (i_rx_byte == CONNECT_BYTE) begin
                    n_connected = 1'b1;
                end
            end
            FUNC_BEACON: begin
                if (!r_connected) begin
                    o_push.count = 2'd1;
                    o_push.w0    = '{data: BEACON_BYTE, last: 1'b1};
                end
            end
            default: begin
            end
        endcase
        // Drop everything unless the item is really taken.
        if (!i_accept) begin
            o_push.count = 2'd0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cpt       <= CPT_RESET;
            r_position  <= '0;
            r_a_rising  <= 1'b1;
            r_b_rising  <= 1'b1;
            r_connected <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_cpt <= i_cfg_data;
            end
            if (i_accept) begin
                r_position  <= n_position;
                r_a_rising  <= n_a_rising;
                r_b_rising  <= n_b_rising;
                r_connected <= n_connected;
            end
        end
    end

    assign o_connected = r_connected;

endmodule

/* sv/qps_out_queue.sv */
// Three-entry shifting result queue: takes up to two words a cycle, gives one while i_ready is high.
// Depends on qps_pkg.
`timescale 1ns / 1ps

module qps_out_queue (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  qps_pkg::t_push i_push,
    output logic           o_space,
    output logic           o_valid,
    input  logic           i_ready,
    output qps_pkg::t_word o_word,
    output logic [1:0]     o_count
);
    import qps_pkg::*;

    t_word      r_q [3];
    t_word      n_q [3];
    t_word      shifted [3];
    logic [1:0] r_count, n_count;
    logic [1:0] base;
    logic       pop;

    always_comb begin
        pop        = (r_count != 2'd0) && i_ready;
        base       = r_count - {1'b0, pop};
        n_count    = base + i_push.count;
        // Advance the queue by one on pop; head is always entry zero.
        shifted[0] = pop ? r_q[1] : r_q[0];
        shifted[1] = pop ? r_q[2] : r_q[1];
        shifted[2] = r_q[2];
        for (int i = 0; i < 3; i++) begin
            if (2'(i) < base) begin
                n_q[i] = shifted[i];
            end else if (2'(i) == base) begin
                n_q[i] = i_push.w0;
            end else begin
                n_q[i] = i_push.w1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= 2'd0;
        end else begin
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        for (int i = 0; i < 3; i++) begin
            r_q[i] <= n_q[i];
        end
    end

    // Room for a full two-word run after this cycle's pop is not counted.
    assign o_space = (r_count < 2'd2);
    assign o_valid = (r_count != 2'd0);
    assign o_word  = r_q[0];
    assign o_count = r_count;

endmodule

/* sv/quadrature_position_sampler.sv */
// Quadrature position sampler: counts encoder edges into a wrapping
// position and streams it out as serial words on request.
//
// Input channel (i_valid / o_ready, fields i_func, i_other_level, i_rx_byte):
// one event a word: edge on A or B, sample tick, received byte, beacon tick.
// Output channel (o_valid / i_ready, fields o_tx_byte, o_last): a sample tick
// after the connect byte yields the low then the high position byte; a
// beacon tick before it yields one beacon byte. Other events yield nothing.
// The words of an event enter the registered result queue when the event is taken.
// Throughput: one event a cycle while the receiver keeps up; a sample tick
// yields two output words, so sample ticks that follow one another are held
// back by o_ready, set by the single output port of the three-entry result queue.
// When the receiver stalls, queued words hold and o_ready drops once fewer
// than two free entries remain; the state does not move meanwhile.
// i_cfg_we writes counts_per_turn from i_cfg_data at once; write it only idle.
// Reset (i_rst_n low, synchronous): position 0, both channels expect a
// rising edge, link not connected, counts_per_turn 910, queue empty.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module quadrature_position_sampler (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_valid,
    output logic                        o_ready,
    input  logic [qps_pkg::FUNC_W-1:0]  i_func,
    input  logic                        i_other_level,
    input  logic [qps_pkg::BYTE_W-1:0]  i_rx_byte,
    output logic                        o_valid,
    input  logic                        i_ready,
    output logic [qps_pkg::BYTE_W-1:0]  o_tx_byte,
    output logic                        o_last,
    input  logic                        i_cfg_we,
    input  logic [qps_pkg::CPT_W-1:0]   i_cfg_data
);
    import qps_pkg::*;

    t_push      push;
    t_word      head;
    logic       accept;
    logic       connected;
    logic [1:0] q_count;

    assign accept = i_valid && o_ready;

    qps_core u_core (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_accept      (accept),
        .i_func        (i_func),
        .i_other_level (i_other_level),
        .i_rx_byte     (i_rx_byte),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_data    (i_cfg_data),
        .o_push        (push),
        .o_connected   (connected)
    );

    qps_out_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .o_space (o_ready),
        .o_valid (o_valid),
        .i_ready (i_ready),
        .o_word  (head),
        .o_count (q_count)
    );

    assign o_tx_byte = head.data;
    assign o_last    = head.last;

    `QPS_ASSERT_NEXT(a_sample_shows, i_clk, i_rst_n, accept && i_func == FUNC_SAMPLE && connected, o_valid, "sample tick gave no word")
    `QPS_ASSERT(a_low_has_high, i_clk, i_rst_n, !(o_valid && !o_last) || q_count >= 2'd2, "low byte without its high byte")
    `QPS_ASSERT_NEXT(a_sticky_link, i_clk, i_rst_n, connected, connected, "link dropped without reset")
    `QPS_ASSERT(a_no_overflow, i_clk, i_rst_n, !accept || push.count <= 2'd2, "queue push too wide")

endmodule
